FILE: src/cri_pkg.sv
// ----------------------------------------------------------------------------
// cri_pkg - shared types and constants of the register instruction executor
// Holds the decoded instruction format, status codes, condition codes and
// the helpers that compute them.
// ----------------------------------------------------------------------------
package cri_pkg;

	// Instruction address width default and queue depth
	localparam int ADDRESS_BITS_DEF = 15;
	localparam int QUEUE_DEPTH      = 2;

	// Field widths of the channels and the banked register file size
	localparam int DATA_W    = 8;
	localparam int OUT_ADDR_W = 15;
	localparam int NUM_BANKED = 6;
	localparam int BANK_IDX_W = $clog2(NUM_BANKED);

	// Upper status word keeps only these bits
	localparam logic [DATA_W-1:0] PSU_MASK = 8'hE7;

	// Lower status word bit positions
	localparam int PSL_BANK_BIT = 4;
	localparam int PSL_COM_BIT  = 1;
	localparam int PSL_CC_HI    = 7;
	localparam int PSL_CC_LO    = 6;

	// Opcode groups (upper six bits) and whole opcodes
	localparam logic [5:0] GRP_LODZ = 6'b000000;
	localparam logic [5:0] GRP_LODI = 6'b000001;
	localparam logic [5:0] GRP_EORZ = 6'b001000;
	localparam logic [5:0] GRP_ANDZ = 6'b010000;
	localparam logic [5:0] GRP_IORZ = 6'b011000;
	localparam logic [5:0] GRP_STRZ = 6'b110000;
	localparam logic [5:0] GRP_COMZ = 6'b111000;
	localparam logic [5:0] GRP_COMI = 6'b111001;
	localparam logic [7:0] OPC_ZERO = 8'h00;
	localparam logic [7:0] OPC_HALT = 8'h40;
	localparam logic [7:0] OPC_LPSU = 8'h92;
	localparam logic [7:0] OPC_LPSL = 8'h93;
	localparam logic [7:0] OPC_NOP  = 8'hC0;

	// Decoded operation
	typedef enum logic [3:0] {
		OP_LODZ,
		OP_LODI,
		OP_EORZ,
		OP_ANDZ,
		OP_IORZ,
		OP_LPSU,
		OP_LPSL,
		OP_NOP,
		OP_STRZ,
		OP_COMZ,
		OP_COMI,
		OP_HALT,
		OP_BAD
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_DONE = 2'd0,
		STATUS_HALT = 2'd1,
		STATUS_STOP = 2'd2
	} status_t;

	// Condition codes
	localparam logic [1:0] CC_ZERO = 2'b00;
	localparam logic [1:0] CC_POS  = 2'b01;
	localparam logic [1:0] CC_NEG  = 2'b10;

	// One decoded instruction waiting in the queue
	typedef struct packed {
		op_t              op;
		logic [1:0]       rsel;
		logic [DATA_W-1:0] imm;
	} instr_t;

	// Condition code of a value
	function automatic logic [1:0] cc_of(input logic [DATA_W-1:0] v);
		logic [1:0] cc;
		if (v == '0) begin
			cc = CC_ZERO;
		end else if (v[DATA_W-1]) begin
			cc = CC_NEG;
		end else begin
			cc = CC_POS;
		end
		return cc;
	endfunction

	// Condition code of a compare, unsigned when umode is set
	function automatic logic [1:0] cc_compare(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic umode);
		logic gt;
		logic [1:0] cc;
		gt = umode ? (a > b) : ($signed(a) > $signed(b));
		if (a == b) begin
			cc = CC_ZERO;
		end else if (gt) begin
			cc = CC_POS;
		end else begin
			cc = CC_NEG;
		end
		return cc;
	endfunction

endpackage

FILE: src/cri_ifs.sv
// ----------------------------------------------------------------------------
// cri_ifs - channel interfaces of the register instruction executor
// Instruction channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cri_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [cri_pkg::DATA_W-1:0] func;
	logic [cri_pkg::DATA_W-1:0] immediate;

	modport source(output valid, func, immediate, input ready);
	modport sink(input valid, func, immediate, output ready);
endinterface

interface cri_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [cri_pkg::OUT_ADDR_W-1:0] next_address;
	logic [cri_pkg::DATA_W-1:0]     accumulator;
	logic [cri_pkg::DATA_W-1:0]     status_lower;
	logic [cri_pkg::DATA_W-1:0]     status_upper;

	modport source(output valid, status, next_address, accumulator, status_lower,
		status_upper, input ready);
	modport sink(input valid, status, next_address, accumulator, status_lower,
		status_upper, output ready);
endinterface

FILE: src/cri_front.sv
// ----------------------------------------------------------------------------
// cri_front - instruction intake and decode
// Accepts instruction beats while the queue has room and classifies the
// opcode into an operation and register select.
// ----------------------------------------------------------------------------
module cri_front (
	cri_cmd_if.sink            cmd,
	input  logic               full,
	output logic               push,
	output cri_pkg::instr_t    push_data
);

	logic [5:0] grp;
	logic [1:0] rsel;

	// Take a beat whenever the queue can hold it
	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	assign grp  = cmd.func[7:2];
	assign rsel = cmd.func[1:0];

	// Classify the opcode
	always_comb begin
		push_data.rsel = rsel;
		push_data.imm  = cmd.immediate;
		push_data.op   = cri_pkg::OP_BAD;
		if (cmd.func == cri_pkg::OPC_ZERO) begin
			push_data.op = cri_pkg::OP_BAD;
		end else if (cmd.func == cri_pkg::OPC_HALT) begin
			push_data.op = cri_pkg::OP_HALT;
		end else if (cmd.func == cri_pkg::OPC_LPSU) begin
			push_data.op = cri_pkg::OP_LPSU;
		end else if (cmd.func == cri_pkg::OPC_LPSL) begin
			push_data.op = cri_pkg::OP_LPSL;
		end else if (cmd.func == cri_pkg::OPC_NOP) begin
			push_data.op = cri_pkg::OP_NOP;
		end else begin
			case (grp)
				cri_pkg::GRP_LODZ: push_data.op = cri_pkg::OP_LODZ;
				cri_pkg::GRP_LODI: push_data.op = cri_pkg::OP_LODI;
				cri_pkg::GRP_EORZ: push_data.op = cri_pkg::OP_EORZ;
				cri_pkg::GRP_ANDZ: push_data.op = cri_pkg::OP_ANDZ;
				cri_pkg::GRP_IORZ: push_data.op = cri_pkg::OP_IORZ;
				cri_pkg::GRP_STRZ: push_data.op = cri_pkg::OP_STRZ;
				cri_pkg::GRP_COMZ: push_data.op = cri_pkg::OP_COMZ;
				cri_pkg::GRP_COMI: push_data.op = cri_pkg::OP_COMI;
				default:           push_data.op = cri_pkg::OP_BAD;
			endcase
		end
	end

endmodule

FILE: src/cri_queue.sv
// ----------------------------------------------------------------------------
// cri_queue - short instruction queue between decode and execute
// Circular buffer of decoded instructions; lets each side stall on its own.
// ----------------------------------------------------------------------------
module cri_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cri_pkg::instr_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output cri_pkg::instr_t pop_data
);

	localparam int DEPTH = cri_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cri_pkg::instr_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !(pop && pop_valid)) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop && pop_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store an entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/cri_back.sv
// ----------------------------------------------------------------------------
// cri_back - instruction execute and result register
// Holds the register file, status words and address, executes one queued
// instruction per cycle while the result is not stalled and registers the result beat.
// ----------------------------------------------------------------------------
module cri_back #(
	parameter int ADDRESS_BITS = cri_pkg::ADDRESS_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  cri_pkg::instr_t q_data,
	output logic            pop,
	cri_rsp_if.source       rsp
);

	localparam int DW = cri_pkg::DATA_W;
	localparam int OW = cri_pkg::OUT_ADDR_W;
	localparam int BW = cri_pkg::BANK_IDX_W;

	// Architectural state
	logic [DW-1:0]           r0_q;
	logic [DW-1:0]           bank_q [cri_pkg::NUM_BANKED];
	logic [DW-1:0]           psl_q;
	logic [DW-1:0]           psu_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic                    stop_q;
	logic                    out_valid_q;

	// Execute results
	logic [BW-1:0]           bank_idx;
	logic [DW-1:0]           rv;
	logic [DW-1:0]           r0_d;
	logic [DW-1:0]           psl_d;
	logic [DW-1:0]           psu_d;
	logic                    bank_we;
	logic [DW-1:0]           bank_wd;
	logic                    cc_set;
	logic [1:0]              cc_new;
	logic                    adv2;
	cri_pkg::status_t        status_d;
	logic [ADDRESS_BITS-1:0] addr_d;
	logic [ADDRESS_BITS+OW-1:0] addr_ext;
	logic                    exec;

	// Pop when the result register is free or being drained
	assign pop  = q_valid && (!out_valid_q || rsp.ready);
	assign exec = pop && !stop_q;

	// Select the banked register for R1..R3
	always_comb begin
		bank_idx = '0;
		if (q_data.rsel != 2'd0) begin
			bank_idx = BW'(q_data.rsel) - BW'(1) +
				(psl_q[cri_pkg::PSL_BANK_BIT] ? BW'(3) : BW'(0));
		end
		rv = (q_data.rsel == 2'd0) ? r0_q : bank_q[bank_idx];
	end

	// Execute one instruction
	always_comb begin
		r0_d     = r0_q;
		psl_d    = psl_q;
		psu_d    = psu_q;
		bank_we  = 1'b0;
		bank_wd  = r0_q;
		cc_set   = 1'b0;
		cc_new   = cri_pkg::CC_ZERO;
		adv2     = 1'b0;
		status_d = cri_pkg::STATUS_DONE;
		case (q_data.op)
			cri_pkg::OP_LODZ: begin
				r0_d   = rv;
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_of(rv);
			end
			cri_pkg::OP_LODI: begin
				if (q_data.rsel == 2'd0) begin
					r0_d = q_data.imm;
				end else begin
					bank_we = 1'b1;
					bank_wd = q_data.imm;
				end
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_of(q_data.imm);
				adv2   = 1'b1;
			end
			cri_pkg::OP_EORZ: begin
				r0_d   = r0_q ^ rv;
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_of(r0_q ^ rv);
			end
			cri_pkg::OP_ANDZ: begin
				r0_d   = r0_q & rv;
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_of(r0_q & rv);
			end
			cri_pkg::OP_IORZ: begin
				r0_d   = r0_q | rv;
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_of(r0_q | rv);
			end
			cri_pkg::OP_LPSU: begin
				psu_d = r0_q & cri_pkg::PSU_MASK;
			end
			cri_pkg::OP_LPSL: begin
				psl_d = r0_q;
			end
			cri_pkg::OP_NOP: begin
				cc_set = 1'b0;
			end
			cri_pkg::OP_STRZ: begin
				bank_we = 1'b1;
				bank_wd = r0_q;
				cc_set  = 1'b1;
				cc_new  = cri_pkg::cc_of(r0_q);
			end
			cri_pkg::OP_COMZ: begin
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_compare(r0_q, rv, psl_q[cri_pkg::PSL_COM_BIT]);
			end
			cri_pkg::OP_COMI: begin
				cc_set = 1'b1;
				cc_new = cri_pkg::cc_compare(rv, q_data.imm, psl_q[cri_pkg::PSL_COM_BIT]);
				adv2   = 1'b1;
			end
			cri_pkg::OP_HALT: begin
				status_d = cri_pkg::STATUS_HALT;
			end
			default: begin
				status_d = cri_pkg::STATUS_STOP;
			end
		endcase
		if (cc_set) begin
			psl_d[cri_pkg::PSL_CC_HI:cri_pkg::PSL_CC_LO] = cc_new;
		end
		addr_d   = addr_q + (adv2 ? ADDRESS_BITS'(2) : ADDRESS_BITS'(1));
		addr_ext = {{OW{1'b0}}, addr_d};
	end

	// Update state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q        <= '0;
			psl_q       <= '0;
			psu_q       <= '0;
			addr_q      <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < cri_pkg::NUM_BANKED; i++) begin
				bank_q[i] <= '0;
			end
		end else begin
			if (exec) begin
				r0_q        <= r0_d;
				psl_q       <= psl_d;
				psu_q       <= psu_d;
				addr_q      <= addr_d;
				stop_q      <= (status_d != cri_pkg::STATUS_DONE);
				out_valid_q <= 1'b1;
				if (bank_we) begin
					bank_q[bank_idx] <= bank_wd;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			rsp.status       <= status_d;
			rsp.next_address <= addr_ext[OW-1:0];
			rsp.accumulator  <= r0_d;
			rsp.status_lower <= psl_d;
			rsp.status_upper <= psu_d & cri_pkg::PSU_MASK;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

FILE: src/cpu_register_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// cpu_register_instruction_executor_core - 2650-style register subset unit
// Decodes and executes one register instruction per beat and returns the
// accumulator, status words, next address and an execution status.
//
//   Channel  Dir  Payload                                            Beats
//   cmd      in   func[7:0], immediate[7:0]                          1 per instr
//   rsp      out  status[1:0], next_address[14:0], accumulator[7:0], 0 or 1
//                 status_lower[7:0], status_upper[7:0]
//
// One instruction per cycle sustained while the result channel is not stalled;
// a result is registered from the combinational execute of the register file
// and condition code as the instruction leaves the queue.
// A two-entry queue separates decode from execute; a stalled result stalls
// execute only, and intake continues until the queue fills.
// After HALT, opcode 00 or an unknown opcode, further beats are accepted and
// dropped with no result until reset.
// Reset clears all registers, status words, the address and the queue.
// ----------------------------------------------------------------------------
module cpu_register_instruction_executor_core #(
	parameter int ADDRESS_BITS = cri_pkg::ADDRESS_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cri_cmd_if.sink   cmd,
	cri_rsp_if.source rsp
);

	logic            push;
	cri_pkg::instr_t push_data;
	logic            full;
	logic            pop;
	logic            q_valid;
	cri_pkg::instr_t q_data;

	// Intake and decode
	cri_front u_front (
		.cmd       (cmd),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue
	cri_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	// Execute and result register
	cri_back #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule
